FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: design/scl_pkg.sv
package scl_pkg;

   localparam int MAX_LEN     = 16;
   localparam int STEP_BITS   = 48;
   localparam int DIGIT_W     = 8;
   localparam int K_W         = 9;
   localparam int MIN_LEN_W   = 5;
   localparam int LEN_W       = $clog2(MAX_LEN + 1);
   localparam int IDX_W       = $clog2(MAX_LEN);
   localparam int BIT_CNT_W   = $clog2(STEP_BITS);
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 5;
   localparam int REG_IDX_W   = 2;

   localparam logic [REG_IDX_W-1:0] REG_ALPHABET = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_STEP     = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_MIN_LEN  = 2'd2;

   localparam logic [K_W-1:0]       ALPHABET_RESET = 9'd26;
   localparam logic [STEP_BITS-1:0] STEP_RESET     = 48'd1;
   localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET  = 5'd1;

   typedef struct packed {
      logic [K_W-1:0]       alphabet_size;
      logic [STEP_BITS-1:0] step_size;
      logic [MIN_LEN_W-1:0] min_length;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [STEP_BITS-1:0] dividend;
      logic [K_W-1:0]       divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [STEP_BITS-1:0] quotient;
      logic [DIGIT_W-1:0]   remainder;
   } div_rsp_type;

endpackage

FILE: design/shortlex_counter_advance_top.sv
// Shortlex start-word counter for splitting a search keyspace into work units.
// Each item on the req channel with advance set returns the current start word
// on the rsp channel, one item per symbol from the leftmost, with tlast on the
// final symbol; an item with advance clear is taken and causes nothing.
// After the last symbol is loaded into the output register the word is advanced
// by step_size in bijective base alphabet_size, one digit at a time from the right.
// Each digit that still sees a carry passes through a bit-serial divider that
// works through the 48-bit carry; digits with no carry left skip the divider.
// After an item is taken the block moves from IDLE to EMIT, which loads each
// symbol into the output register once that register is free; a saturated word
// returns to IDLE from ADV without the digit loop.
// Only one item is in work at a time; req_tready is high while the block is idle.
// A stalled rsp channel holds the output register and pauses symbol emission.
// Reset clears the word, the started and exhausted flags, and loads the
// registers with alphabet_size 26, step_size 1 and min_length 1.
// Registers sit at byte addresses 0, 8 and 16 on the 64-bit APB port.
`include "assert_macros.svh"

module shortlex_counter_advance_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [scl_pkg::REQ_TDATA_W-1:0]    req_tdata,   // [0] advance
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [scl_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // [7:0] digit, [11:8] position,
                                                           // [16:12] word_length
   output logic                               rsp_tlast,
   output logic                               rsp_tuser,   // [0] exhausted
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [scl_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [scl_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [scl_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import scl_pkg::*;

   logic [K_W-1:0]       alphabet_ff;
   logic [STEP_BITS-1:0] step_ff;
   logic [MIN_LEN_W-1:0] min_len_ff;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;
   cfg_type              cfg;
   logic [DIGIT_W-1:0]   digit;
   logic [IDX_W-1:0]     position;
   logic [LEN_W-1:0]     word_length;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:3];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         alphabet_ff <= ALPHABET_RESET;
         step_ff     <= STEP_RESET;
         min_len_ff  <= MIN_LEN_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            REG_ALPHABET: alphabet_ff <= csr_pwdata[K_W-1:0];
            REG_STEP:     step_ff     <= csr_pwdata[STEP_BITS-1:0];
            REG_MIN_LEN:  min_len_ff  <= csr_pwdata[MIN_LEN_W-1:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_ALPHABET: csr_prdata = CSR_DATA_W'(alphabet_ff);
         REG_STEP:     csr_prdata = CSR_DATA_W'(step_ff);
         REG_MIN_LEN:  csr_prdata = CSR_DATA_W'(min_len_ff);
         default:      csr_prdata = '0;
      endcase
   end

   assign cfg.alphabet_size = alphabet_ff;
   assign cfg.step_size     = step_ff;
   assign cfg.min_length    = min_len_ff;

   scl_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_advance     (req_tdata[0]),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_digit       (digit),
      .rsp_position    (position),
      .rsp_word_length (word_length),
      .rsp_last        (rsp_tlast),
      .rsp_exhausted   (rsp_tuser)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - DIGIT_W - IDX_W - LEN_W){1'b0}},
                       word_length, position, digit};

   `ASSERT_IMPLIES(a_pos_in_word, rsp_tvalid, (word_length != '0) && (LEN_W'(position) < word_length))
   `ASSERT_IMPLIES(a_last_at_end, rsp_tvalid && rsp_tlast, (LEN_W'(position) + 1'b1) == word_length)
   `ASSERT_IMPLIES(a_exh_full, rsp_tvalid && rsp_tuser, word_length == LEN_W'(MAX_LEN))
   `ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready && req_tdata[0], !req_tready)

endmodule

FILE: design/scl_div.sv
module scl_div (
   input  logic                 clock,
   input  logic                 reset,
   input  scl_pkg::div_req_type div_req,
   output scl_pkg::div_rsp_type div_rsp
);
   import scl_pkg::*;

   logic [STEP_BITS-1:0] quo_ff, quo_in;
   logic [DIGIT_W-1:0]   rem_ff, rem_in;
   logic [BIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [K_W-1:0]       shifted;
   logic [K_W-1:0]       diff;
   logic                 fits;

   assign shifted = {rem_ff, quo_ff[STEP_BITS-1]};
   assign fits    = (shifted >= div_req.divisor);
   assign diff    = shifted - div_req.divisor;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[STEP_BITS-2:0], fits};
         rem_in = fits ? diff[DIGIT_W-1:0] : shifted[DIGIT_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == BIT_CNT_W'(STEP_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

FILE: design/scl_ctrl.sv
module scl_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  scl_pkg::cfg_type              cfg,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          req_advance,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [scl_pkg::DIGIT_W-1:0]   rsp_digit,
   output logic [scl_pkg::IDX_W-1:0]     rsp_position,
   output logic [scl_pkg::LEN_W-1:0]     rsp_word_length,
   output logic                          rsp_last,
   output logic                          rsp_exhausted
);
   import scl_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EMIT  = 3'd1;
   localparam logic [2:0] S_ADV   = 3'd2;
   localparam logic [2:0] S_DIGIT = 3'd3;
   localparam logic [2:0] S_DIVD  = 3'd4;
   localparam logic [2:0] S_EXT   = 3'd5;
   localparam logic [2:0] S_DIVE  = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [DIGIT_W-1:0]   digits_ff [MAX_LEN];
   logic [DIGIT_W-1:0]   digits_in [MAX_LEN];
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [LEN_W-1:0]     idx_ff, idx_in;
   logic                 started_ff, started_in;
   logic                 sat_ff, sat_in;
   logic [STEP_BITS-1:0] carry_ff, carry_in;
   logic [K_W-1:0]       k_ff, k_in;
   logic [DIGIT_W-1:0]   b_ff, b_in;

   logic                 out_valid_ff, out_valid_in;
   logic [DIGIT_W-1:0]   out_digit_ff, out_digit_in;
   logic [IDX_W-1:0]     out_pos_ff, out_pos_in;
   logic [LEN_W-1:0]     out_len_ff, out_len_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_exh_ff, out_exh_in;

   logic [K_W-1:0]       k_clamped;
   logic [LEN_W-1:0]     min_clamped;
   logic [LEN_W-1:0]     emit_sum;
   logic [LEN_W-1:0]     adv_sum;
   logic [IDX_W-1:0]     adv_idx;
   logic [IDX_W-1:0]     rd_idx;
   logic [DIGIT_W-1:0]   rd_digit;
   logic [DIGIT_W-1:0]   k_top;
   logic [DIGIT_W-1:0]   b_clamped;
   logic [K_W-1:0]       t_sum;
   logic [K_W-1:0]       t_fix;
   logic [K_W-1:0]       d_ext;
   logic                 slot_free;
   logic                 emit_last;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   scl_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      if (cfg.alphabet_size < K_W'(2)) begin
         k_clamped = K_W'(2);
      end else if (cfg.alphabet_size > K_W'(256)) begin
         k_clamped = K_W'(256);
      end else begin
         k_clamped = cfg.alphabet_size;
      end
      if (cfg.min_length == '0) begin
         min_clamped = LEN_W'(1);
      end else if (LEN_W'(cfg.min_length) > LEN_W'(MAX_LEN)) begin
         min_clamped = LEN_W'(MAX_LEN);
      end else begin
         min_clamped = LEN_W'(cfg.min_length);
      end
   end

   assign emit_sum  = LEN_W'(MAX_LEN) - len_ff + idx_ff;
   assign adv_sum   = LEN_W'(MAX_LEN - 1) - idx_ff;
   assign adv_idx   = adv_sum[IDX_W-1:0];
   assign rd_idx    = (state_ff == S_EMIT) ? emit_sum[IDX_W-1:0] : adv_idx;
   assign rd_digit  = digits_ff[rd_idx];
   assign k_top     = DIGIT_W'(k_ff - 1'b1);
   assign b_clamped = ({1'b0, rd_digit} > (k_ff - 1'b1)) ? k_top : rd_digit;
   assign t_sum     = K_W'(b_ff) + K_W'(1) + K_W'(div_rsp.remainder);
   assign t_fix     = (t_sum > k_ff) ? (t_sum - k_ff) : t_sum;
   assign d_ext     = (div_rsp.remainder == '0) ? k_ff : K_W'(div_rsp.remainder);
   assign slot_free = !out_valid_ff || rsp_tready;
   assign emit_last = ((idx_ff + 1'b1) == len_ff);

   always_comb begin
      state_in     = state_ff;
      digits_in    = digits_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      started_in   = started_ff;
      sat_in       = sat_ff;
      carry_in     = carry_ff;
      k_in         = k_ff;
      b_in         = b_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_digit_in = out_digit_ff;
      out_pos_in   = out_pos_ff;
      out_len_in   = out_len_ff;
      out_last_in  = out_last_ff;
      out_exh_in   = out_exh_ff;
      div_req.start    = 1'b0;
      div_req.dividend = carry_ff;
      div_req.divisor  = k_ff;
      req_tready   = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_advance) begin
               if (!started_ff) begin
                  for (int i = 0; i < MAX_LEN; i++) begin
                     digits_in[i] = '0;
                  end
                  len_in     = min_clamped;
                  started_in = 1'b1;
               end
               idx_in   = '0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_digit_in = rd_digit;
               out_pos_in   = idx_ff[IDX_W-1:0];
               out_len_in   = len_ff;
               out_last_in  = emit_last;
               out_exh_in   = sat_ff;
               idx_in       = idx_ff + 1'b1;
               if (emit_last) begin
                  idx_in   = '0;
                  state_in = S_ADV;
               end
            end
         end
         S_ADV: begin
            k_in     = k_clamped;
            carry_in = cfg.step_size;
            idx_in   = '0;
            if (sat_ff) begin
               for (int i = 0; i < MAX_LEN; i++) begin
                  digits_in[i] = DIGIT_W'(k_clamped - 1'b1);
               end
               len_in   = LEN_W'(MAX_LEN);
               state_in = S_IDLE;
            end else begin
               state_in = S_DIGIT;
            end
         end
         S_DIGIT: begin
            if (idx_ff == len_ff) begin
               state_in = S_EXT;
            end else if (carry_ff == '0) begin
               digits_in[adv_idx] = b_clamped;
               idx_in = idx_ff + 1'b1;
            end else begin
               b_in          = b_clamped;
               div_req.start = 1'b1;
               state_in      = S_DIVD;
            end
         end
         S_DIVD: begin
            if (div_rsp.done) begin
               digits_in[adv_idx] = DIGIT_W'(t_fix - 1'b1);
               carry_in = (t_sum > k_ff) ? (div_rsp.quotient + 1'b1) : div_rsp.quotient;
               idx_in   = idx_ff + 1'b1;
               state_in = S_DIGIT;
            end
         end
         S_EXT: begin
            if (carry_ff == '0) begin
               len_in   = idx_ff;
               state_in = S_IDLE;
            end else if (idx_ff == LEN_W'(MAX_LEN)) begin
               for (int i = 0; i < MAX_LEN; i++) begin
                  digits_in[i] = k_top;
               end
               len_in   = LEN_W'(MAX_LEN);
               sat_in   = 1'b1;
               state_in = S_IDLE;
            end else begin
               div_req.start = 1'b1;
               state_in      = S_DIVE;
            end
         end
         S_DIVE: begin
            if (div_rsp.done) begin
               digits_in[adv_idx] = DIGIT_W'(d_ext - 1'b1);
               carry_in = (div_rsp.remainder == '0) ? (div_rsp.quotient - 1'b1)
                                                    : div_rsp.quotient;
               idx_in   = idx_ff + 1'b1;
               state_in = S_EXT;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         idx_ff       <= '0;
         started_ff   <= 1'b0;
         sat_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         idx_ff       <= idx_in;
         started_ff   <= started_in;
         sat_ff       <= sat_in;
         out_valid_ff <= out_valid_in;
      end
      digits_ff    <= digits_in;
      carry_ff     <= carry_in;
      k_ff         <= k_in;
      b_ff         <= b_in;
      out_digit_ff <= out_digit_in;
      out_pos_ff   <= out_pos_in;
      out_len_ff   <= out_len_in;
      out_last_ff  <= out_last_in;
      out_exh_ff   <= out_exh_in;
   end

   assign rsp_tvalid      = out_valid_ff;
   assign rsp_digit       = out_digit_ff;
   assign rsp_position    = out_pos_ff;
   assign rsp_word_length = out_len_ff;
   assign rsp_last        = out_last_ff;
   assign rsp_exhausted   = out_exh_ff;

endmodule
